[rtl/core/acoustic_wave_2d_stencil_core_assert.svh]
// Assertion macros for the acoustic wave stencil core.
// Used by the top level; expects clk and rst in scope.
`ifndef ACOUSTIC_WAVE_2D_STENCIL_CORE_ASSERT_SVH
`define ACOUSTIC_WAVE_2D_STENCIL_CORE_ASSERT_SVH

`define AWSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define AWSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/awsc_pkg.sv]
// Shared types and constants for the acoustic wave stencil core.
// No dependencies.
package awsc_pkg;

  localparam int MAX_ROWS     = 256;
  localparam int MAX_COLS     = 256;
  localparam int ADDR_W       = 16;
  localparam int DIM_W        = 9;
  localparam int PW           = 32;
  localparam int VW           = 16;
  localparam int CHAIN_LEN    = 3;
  localparam int DRAIN_CYCLES = 12;
  localparam int DRAIN_W      = 4;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_RUN  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_COLS  = 3'd1;
  localparam logic [2:0] REG_STEPS = 3'd2;
  localparam logic [2:0] REG_CX    = 3'd3;
  localparam logic [2:0] REG_CY    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [PW-1:0]     left;
    logic [PW-1:0]     center;
    logic [PW-1:0]     right;
    logic [PW-1:0]     up;
    logic [PW-1:0]     down;
    logic [PW-1:0]     old;
    logic [VW-1:0]     vel;
    logic [ADDR_W-1:0] addr;
  } stencil_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [PW-1:0]     value;
  } wb_t;

endpackage

[rtl/core/acoustic_wave_2d_stencil_core.sv]
// Acoustic wave stencil core: memories, scan sequencer, row window, APB registers.
// Depends on awsc_pkg, awsc_cell, awsc_update and the assertion macro header.
//
// Load and read transactions give their result strobe in the next cycle while
// busy stays low, so they stream back to back. A run transaction holds busy
// until its single result: per time step the sequencer visits every column of
// each interior row, reading first along the row and then the row above (the
// field memory has two read ports and each point needs three reads of the
// current field), then drains the eight-stage update pipeline. With fewer than
// three rows or columns a step is only the drain; zero steps answer in the next
// cycle. The strobe cannot be held off by the receiver.
module acoustic_wave_2d_stencil_core import awsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [15:0]        point_index,
  input  logic signed [31:0] pressure_in,
  input  logic [15:0]        velocity_in,
  output logic               strobe,
  output logic signed [31:0] pressure_out,
  output logic               status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [PW-1:0] field_a [1 << ADDR_W];
  logic [PW-1:0] field_b [1 << ADDR_W];
  logic [VW-1:0] velocity_store [1 << ADDR_W];

  logic [DIM_W-1:0] grid_rows, grid_cols;
  logic [15:0]      time_steps;
  logic [47:0]      coef_x, coef_y;
  logic             newest_is_b;

  state_t            state;
  logic [DIM_W-1:0]  row, col;
  logic              phase;
  logic [ADDR_W-1:0] base;
  logic [15:0]       step_cnt;
  logic [DRAIN_W-1:0] drain_cnt;

  logic [DIM_W-1:0]  rows_e, cols_e;
  logic [16:0]       total;
  logic              accept, idx_ok, load_ok, small_grid;
  logic [ADDR_W-1:0] mid_addr, ctr_addr, up_addr, dn_addr;

  logic [ADDR_W-1:0] cur_ra0, cur_ra1, old_ra0;
  logic [ADDR_W-1:0] a_ra0, a_ra1, b_ra0, b_ra1;
  logic [PW-1:0]     a_rd0, a_rd1, b_rd0, b_rd1, cur_d0, cur_d1, old_d0;
  logic [VW-1:0]     v_rd;
  logic              a_we, b_we;
  logic [PW-1:0]     a_wd, b_wd;

  logic              mid_d, emit_d;
  logic [ADDR_W-1:0] ctr_d;
  logic [PW-1:0]     win [CHAIN_LEN+1];
  stencil_t          pt;
  wb_t               wb;

  logic              res_read, res_b;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign rows_e = (grid_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_rows;
  assign cols_e = (grid_cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_cols;
  assign total  = rows_e * cols_e;
  assign idx_ok = {1'b0, point_index} < total;
  assign load_ok = accept && (action == ACT_LOAD) && idx_ok;
  assign small_grid = (rows_e < DIM_W'(3)) || (cols_e < DIM_W'(3));

  assign mid_addr = base + ADDR_W'(col);
  assign ctr_addr = mid_addr - ADDR_W'(1);
  assign up_addr  = ctr_addr - ADDR_W'(cols_e);
  assign dn_addr  = ctr_addr + ADDR_W'(cols_e);

  always_comb begin
    cur_ra0 = point_index;
    cur_ra1 = dn_addr;
    old_ra0 = ctr_addr;
    if (state == ST_SCAN) begin
      cur_ra0 = phase ? up_addr : mid_addr;
    end
  end

  assign a_ra0 = newest_is_b ? old_ra0 : cur_ra0;
  assign b_ra0 = newest_is_b ? cur_ra0 : old_ra0;
  assign a_ra1 = cur_ra1;
  assign b_ra1 = cur_ra1;
  assign cur_d0 = newest_is_b ? b_rd0 : a_rd0;
  assign cur_d1 = newest_is_b ? b_rd1 : a_rd1;
  assign old_d0 = newest_is_b ? a_rd0 : b_rd0;

  always_comb begin
    a_we = load_ok || (wb.valid && newest_is_b);
    b_we = load_ok || (wb.valid && !newest_is_b);
    a_wd = wb.value;
    b_wd = wb.value;
    if (load_ok) begin
      a_wd = newest_is_b ? '0 : pressure_in;
      b_wd = newest_is_b ? pressure_in : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      field_a[load_ok ? point_index : wb.addr] <= a_wd;
    end
    if (b_we) begin
      field_b[load_ok ? point_index : wb.addr] <= b_wd;
    end
    if (load_ok) begin
      velocity_store[point_index] <= velocity_in;
    end
    a_rd0 <= field_a[a_ra0];
    a_rd1 <= field_a[a_ra1];
    b_rd0 <= field_b[b_ra0];
    b_rd1 <= field_b[b_ra1];
    v_rd  <= velocity_store[ctr_addr];
  end

  assign win[0] = cur_d0;
  for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_chain
    awsc_cell u_cell (
      .clk      (clk),
      .shift_en (mid_d),
      .din      (win[g]),
      .dout     (win[g+1])
    );
  end

  always_comb begin
    pt.valid  = emit_d;
    pt.right  = win[1];
    pt.center = win[2];
    pt.left   = win[3];
    pt.up     = cur_d0;
    pt.down   = cur_d1;
    pt.old    = old_d0;
    pt.vel    = v_rd;
    pt.addr   = ctr_d;
  end

  awsc_update u_update (
    .clk    (clk),
    .rst    (rst),
    .pt     (pt),
    .coef_x (coef_x),
    .coef_y (coef_y),
    .wb     (wb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_d  <= 1'b0;
      emit_d <= 1'b0;
    end else begin
      mid_d  <= (state == ST_SCAN) && !phase;
      emit_d <= (state == ST_SCAN) && phase && (col >= DIM_W'(2));
    end
    ctr_d <= ctr_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      newest_is_b <= 1'b0;
      strobe      <= 1'b0;
      status      <= 1'b0;
      res_read    <= 1'b0;
      res_b       <= 1'b0;
      row         <= '0;
      col         <= '0;
      phase       <= 1'b0;
      base        <= '0;
      step_cnt    <= '0;
      drain_cnt   <= '0;
    end else begin
      strobe   <= 1'b0;
      res_read <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            status <= 1'b0;
            res_b  <= newest_is_b;
            case (action)
              ACT_LOAD: begin
                strobe <= 1'b1;
                status <= !idx_ok;
              end
              ACT_READ: begin
                strobe   <= 1'b1;
                status   <= !idx_ok;
                res_read <= idx_ok;
              end
              ACT_RUN: begin
                step_cnt  <= '0;
                drain_cnt <= '0;
                row       <= DIM_W'(1);
                col       <= '0;
                phase     <= 1'b0;
                base      <= ADDR_W'(cols_e);
                if (time_steps == 16'd0) begin
                  strobe <= 1'b1;
                end else begin
                  state <= small_grid ? ST_DRAIN : ST_SCAN;
                end
              end
              default: begin
                strobe <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          phase <= !phase;
          if (phase) begin
            if (col == cols_e - DIM_W'(1)) begin
              col <= '0;
              if (row == rows_e - DIM_W'(2)) begin
                state     <= ST_DRAIN;
                drain_cnt <= '0;
              end else begin
                row  <= row + DIM_W'(1);
                base <= base + ADDR_W'(cols_e);
              end
            end else begin
              col <= col + DIM_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + DRAIN_W'(1);
          if (drain_cnt == DRAIN_W'(DRAIN_CYCLES - 1)) begin
            newest_is_b <= !newest_is_b;
            step_cnt    <= step_cnt + 16'd1;
            drain_cnt   <= '0;
            row         <= DIM_W'(1);
            col         <= '0;
            phase       <= 1'b0;
            base        <= ADDR_W'(cols_e);
            if (step_cnt + 16'd1 == time_steps) begin
              state  <= ST_IDLE;
              strobe <= 1'b1;
              status <= 1'b0;
            end else if (!small_grid) begin
              state <= ST_SCAN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign pressure_out = res_read ? (res_b ? b_rd0 : a_rd0) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows  <= DIM_W'(256);
      grid_cols  <= DIM_W'(256);
      time_steps <= '0;
      coef_x     <= '0;
      coef_y     <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_ROWS:  grid_rows  <= pwdata[DIM_W-1:0];
        REG_COLS:  grid_cols  <= pwdata[DIM_W-1:0];
        REG_STEPS: time_steps <= pwdata[15:0];
        REG_CX:    coef_x     <= pwdata[47:0];
        REG_CY:    coef_y     <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_ROWS:  prdata = {55'd0, grid_rows};
      REG_COLS:  prdata = {55'd0, grid_cols};
      REG_STEPS: prdata = {48'd0, time_steps};
      REG_CX:    prdata = {16'd0, coef_x};
      REG_CY:    prdata = {16'd0, coef_y};
      default:   prdata = '0;
    endcase
  end

`include "acoustic_wave_2d_stencil_core_assert.svh"

  `AWSC_ASSERT_NOW(a_wb_in_run, wb.valid, (state == ST_SCAN) || (state == ST_DRAIN), "writeback outside run")
  `AWSC_ASSERT_NEXT(a_run_busy, accept && (action == ACT_RUN) && (time_steps != 16'd0), busy, "run not busy")
  `AWSC_ASSERT_NEXT(a_rw_strobe, accept && (action != ACT_RUN), strobe, "missing result")

endmodule

[rtl/core/awsc_cell.sv]
// One cell of the row window: holds a pressure sample, passes it on.
// Depends on awsc_pkg.
module awsc_cell import awsc_pkg::*; (
  input  logic          clk,
  input  logic          shift_en,
  input  logic [PW-1:0] din,
  output logic [PW-1:0] dout
);

  logic [PW-1:0] sample;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sample <= din;
    end
  end

  assign dout = sample;

endmodule

[rtl/core/awsc_update.sv]
// Pipelined leapfrog update of one interior point (eight stages).
// Depends on awsc_pkg.
module awsc_update import awsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  stencil_t    pt,
  input  logic [47:0] coef_x,
  input  logic [47:0] coef_y,
  output wb_t         wb
);

  logic [6:0]              vld;
  logic [ADDR_W-1:0]       addr [7];
  logic signed [PW-1:0]    pc   [7];
  logic signed [PW-1:0]    pold [7];

  logic signed [34:0] lx1, ly1;
  logic [31:0]        v2_1, v2_2, v2_3, v2_4, v2_5;
  logic [57:0]        mxl, mxh, myl, myh;
  logic               sx2, sy2, sx3, sy3;
  logic [81:0]        px, py;
  logic signed [83:0] s4;
  logic [82:0]        mag;
  logic               neg5, neg6, neg7;
  logic [59:0]        m0, m1;
  logic [58:0]        m2;
  logic [115:0]       p7;

  logic signed [34:0] alx, aly;
  logic [83:0]        sx_ext, sy_ext;
  logic [67:0]        q;
  logic [34:0]        qc;
  logic signed [36:0] d, nw;

  assign alx = lx1[34] ? -lx1 : lx1;
  assign aly = ly1[34] ? -ly1 : ly1;
  assign sx_ext = sx3 ? -{2'b00, px} : {2'b00, px};
  assign sy_ext = sy3 ? -{2'b00, py} : {2'b00, py};
  assign q  = p7[115:48];
  assign qc = (q > 68'h4_0000_0000) ? 35'h4_0000_0000 : q[34:0];
  assign d  = neg7 ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
  assign nw = 37'(2 * 37'(pc[6])) - 37'(pold[6]) + d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], pt.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb.valid <= 1'b0;
    end else begin
      wb.valid <= vld[6];
    end
    addr[0] <= pt.addr;
    pc[0]   <= pt.center;
    pold[0] <= pt.old;
    for (int k = 1; k < 7; k++) begin
      addr[k] <= addr[k-1];
      pc[k]   <= pc[k-1];
      pold[k] <= pold[k-1];
    end
    lx1  <= 35'($signed(pt.left)) + 35'($signed(pt.right)) - 35'(2 * 35'($signed(pt.center)));
    ly1  <= 35'($signed(pt.up)) + 35'($signed(pt.down)) - 35'(2 * 35'($signed(pt.center)));
    v2_1 <= pt.vel * pt.vel;
    mxl  <= coef_x[23:0] * alx[33:0];
    mxh  <= coef_x[47:24] * alx[33:0];
    myl  <= coef_y[23:0] * aly[33:0];
    myh  <= coef_y[47:24] * aly[33:0];
    sx2  <= lx1[34];
    sy2  <= ly1[34];
    v2_2 <= v2_1;
    px   <= {mxh, 24'd0} + {24'd0, mxl};
    py   <= {myh, 24'd0} + {24'd0, myl};
    sx3  <= sx2;
    sy3  <= sy2;
    v2_3 <= v2_2;
    s4   <= $signed(sx_ext + sy_ext);
    v2_4 <= v2_3;
    mag  <= s4[83] ? 83'(-s4) : 83'(s4);
    neg5 <= s4[83];
    v2_5 <= v2_4;
    m0   <= mag[27:0] * v2_5;
    m1   <= mag[55:28] * v2_5;
    m2   <= mag[82:56] * v2_5;
    neg6 <= neg5;
    p7   <= {1'b0, m2, 56'd0} + {28'd0, m1, 28'd0} + {56'd0, m0} + (116'd1 << 47);
    neg7 <= neg6;
    wb.addr <= addr[6];
    if (nw > 37'sd2147483647) begin
      wb.value <= 32'h7FFF_FFFF;
    end else if (nw < -37'sd2147483648) begin
      wb.value <= 32'h8000_0000;
    end else begin
      wb.value <= nw[31:0];
    end
  end

endmodule

[test/acoustic_wave_2d_stencil_core_checker.sv]
// Checker for the acoustic wave stencil core: watches the command, result and APB channels.
// Predicts every result from its own copy of the fields and registers; depends on awsc_pkg.
module acoustic_wave_2d_stencil_core_checker import awsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         action,
  input  logic [15:0]        point_index,
  input  logic signed [31:0] pressure_in,
  input  logic [15:0]        velocity_in,
  input  logic               strobe,
  input  logic signed [31:0] pressure_out,
  input  logic               status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output int                 fails,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] pressure;
    logic        status;
  } answer_t;

  logic [31:0] field_a [65536];
  logic [31:0] field_b [65536];
  logic [15:0] vel_mem [65536];
  bit          newest_b;
  logic [8:0]  rows_reg, cols_reg;
  logic [15:0] steps_reg;
  logic [47:0] cx_reg, cy_reg;
  answer_t     answers [$];

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [31:0] leapfrog(input logic [31:0] c, l, r, u, d, old,
                                            input logic [15:0] v);
    longint pc, lx, ly, dl, sum;
    logic signed [127:0] s, mag, q;
    logic [31:0] v2;
    pc = sx(c);
    lx = sx(l) - 2 * pc + sx(r);
    ly = sx(u) - 2 * pc + sx(d);
    v2 = v * v;
    s = $signed({80'd0, cx_reg}) * $signed(128'(lx)) + $signed({80'd0, cy_reg}) * $signed(128'(ly));
    s = s * $signed({96'd0, v2});
    mag = (s < 0) ? -s : s;
    q = (mag + (128'sd1 <<< 47)) >>> 48;
    if (q > (128'sd1 <<< 34)) q = 128'sd1 <<< 34;
    dl = (s < 0) ? -longint'(q) : longint'(q);
    sum = 2 * pc - sx(old) + dl;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  task automatic advance_field(input int rows, input int cols);
    int c;
    for (int n = 0; n < steps_reg; n++) begin
      if (rows >= 3 && cols >= 3) begin
        for (int i = 1; i < rows - 1; i++) begin
          for (int j = 1; j < cols - 1; j++) begin
            c = i * cols + j;
            if (newest_b)
              field_a[c] = leapfrog(field_b[c], field_b[c-1], field_b[c+1], field_b[c-cols],
                                    field_b[c+cols], field_a[c], vel_mem[c]);
            else
              field_b[c] = leapfrog(field_a[c], field_a[c-1], field_a[c+1], field_a[c-cols],
                                    field_a[c+cols], field_b[c], vel_mem[c]);
          end
        end
      end
      newest_b = !newest_b;
    end
  endtask

  always @(posedge clk) begin
    answer_t a, got;
    int rows, cols;
    if (rst) begin
      newest_b = 0;
      rows_reg = 9'd256;
      cols_reg = 9'd256;
      steps_reg = 0;
      cx_reg = 0;
      cy_reg = 0;
      answers.delete();
      fails <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_ROWS:  rows_reg = pwdata[8:0];
          REG_COLS:  cols_reg = pwdata[8:0];
          REG_STEPS: steps_reg = pwdata[15:0];
          REG_CX:    cx_reg = pwdata[47:0];
          REG_CY:    cy_reg = pwdata[47:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        cols = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
        a.pressure = 0;
        a.status = 0;
        case (action)
          ACT_LOAD, ACT_READ: begin
            if (point_index >= rows * cols) begin
              a.status = 1;
            end else if (action == ACT_LOAD) begin
              if (newest_b) begin
                field_b[point_index] = pressure_in;
                field_a[point_index] = 0;
              end else begin
                field_a[point_index] = pressure_in;
                field_b[point_index] = 0;
              end
              vel_mem[point_index] = velocity_in;
            end else begin
              a.pressure = newest_b ? field_b[point_index] : field_a[point_index];
            end
          end
          ACT_RUN: advance_field(rows, cols);
          default: ;
        endcase
        answers.push_back(a);
      end
      if (strobe) begin
        if (answers.size() == 0) begin
          $display("%0t: result with no transaction waiting: pressure %h status %b",
                   $time, pressure_out, status);
          fails <= fails + 1;
        end else begin
          got = answers.pop_front();
          if (pressure_out !== got.pressure || status !== got.status) begin
            $display("%0t: mismatch: expected pressure %h status %b, got pressure %h status %b",
                     $time, got.pressure, got.status, pressure_out, status);
            fails <= fails + 1;
          end
        end
      end
      pending <= answers.size();
    end
  end

  initial pending = 0;
endmodule

[test/acoustic_wave_2d_stencil_core_tb.sv]
// Testbench top for the acoustic wave stencil core: clock, reset, stimulus and verdict.
// Depends on awsc_pkg, the core and acoustic_wave_2d_stencil_core_checker.
module acoustic_wave_2d_stencil_core_tb;
  import awsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int WATCHDOG = 3000000;
  localparam logic [47:0] COEF_MAX = 48'hFFFF_FFFF_FFFF;

  logic clk = 0, rst = 1, start = 0;
  logic [1:0] action = 0;
  logic [15:0] point_index = 0, velocity_in = 0;
  logic signed [31:0] pressure_in = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [5:0] paddr = 0;
  logic [63:0] pwdata = 0;
  logic busy, strobe, status, pready;
  logic signed [31:0] pressure_out;
  logic [63:0] prdata;
  int fails, pending, sent = 0, runs = 0, idle_cycles = 0;
  bit gaps_on = 1;
  logic [15:0] loaded [$];

  always #1 clk = ~clk;

  acoustic_wave_2d_stencil_core dut (.*);
  acoustic_wave_2d_stencil_core_checker checker_i (.*);

  always @(posedge clk) begin
    if ((start && !busy) || strobe || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("acoustic_wave_2d_stencil_core test failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_pressure();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom) >>> $urandom_range(6, 12);
  endfunction

  function automatic logic [15:0] rand_velocity();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [47:0] rand_coef();
    return {$urandom, $urandom} >> $urandom_range(2, 20);
  endfunction

  task automatic send(input logic [1:0] a, input logic [15:0] i, input logic [31:0] p,
                      input logic [15:0] v);
    int r;
    start <= 1;
    action <= a;
    point_index <= i;
    pressure_in <= p;
    velocity_in <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (a == ACT_RUN) runs++;
    r = $urandom_range(0, 99);
    if (gaps_on && r >= 60) begin
      start <= 0;
      repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES + 4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] r, input logic [63:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {r, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic phase(input int rows, input int cols, input int steps,
                       input logic [47:0] cx, input logic [47:0] cy, input int n);
    int total, r;
    logic [15:0] idx;
    drain();
    reg_write(REG_ROWS, rows);
    reg_write(REG_COLS, cols);
    reg_write(REG_STEPS, steps);
    reg_write(REG_CX, cx);
    reg_write(REG_CY, cy);
    gaps_on = ($urandom_range(0, 2) != 0);
    total = (rows > 256 ? 256 : rows) * (cols > 256 ? 256 : cols);
    for (int i = 0; i < total; i++) send(ACT_LOAD, i, rand_pressure(), rand_velocity());
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      idx = $urandom_range(0, total - 1);
      if (r < 55) send(ACT_READ, idx, $urandom, $urandom);
      else if (r < 70) send(ACT_LOAD, idx, rand_pressure(), rand_velocity());
      else if (r < 80) send(r[0] ? ACT_LOAD : ACT_READ, $urandom_range(total, 65535),
                            $urandom, $urandom);
      else if (r < 85) send(ACT_NONE, $urandom, $urandom, $urandom);
      else send(ACT_RUN, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [15:0] idx;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(ACT_LOAD, 16'd0, 32'h7FFF_FFFF, 16'hFFFF);
    send(ACT_LOAD, 16'hFFFF, 32'h8000_0000, 16'd0);
    send(ACT_LOAD, 16'd300, 32'd0, 16'h8000);
    send(ACT_READ, 16'd0, 32'd0, 16'd0);
    send(ACT_READ, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send(ACT_READ, 16'd300, 32'd0, 16'd0);
    send(ACT_NONE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send(ACT_RUN, 16'd0, 32'd0, 16'd0);
    send(ACT_READ, 16'd0, 32'd0, 16'd0);
    drain();
    reg_write(REG_ROWS, 0);
    send(ACT_LOAD, 16'd5, 32'h1234_5678, 16'd3);
    send(ACT_READ, 16'd0, 32'd0, 16'd0);
    drain();
    reg_write(REG_ROWS, 511);
    reg_write(REG_COLS, 511);
    send(ACT_READ, 16'hFFFF, 32'd0, 16'd0);
    send(ACT_READ, 16'd300, 32'd0, 16'd0);
    drain();
    reg_write(REG_ROWS, 256);
    reg_write(REG_COLS, 256);
    loaded = '{16'd0, 16'd300, 16'hFFFF};
    for (int k = 0; k < 60; k++) begin
      if ($urandom_range(0, 1)) begin
        idx = $urandom;
        loaded.push_back(idx);
        send(ACT_LOAD, idx, $urandom, $urandom);
      end else begin
        send(ACT_READ, loaded[$urandom_range(0, loaded.size() - 1)], $urandom, $urandom);
      end
    end

    phase(3, 3, 1, COEF_MAX, COEF_MAX, 25);
    phase(5, 7, 3, rand_coef(), rand_coef(), 50);
    drain();
    phase(4, 9, 2, 48'd0, rand_coef(), 50);
    phase(6, 5, 4, rand_coef(), 48'd0, 50);
    phase(3, 8, 0, rand_coef(), rand_coef(), 30);
    phase(2, 5, 3, rand_coef(), rand_coef(), 30);
    drain();
    reg_write(REG_STEPS, 65535);
    send(ACT_RUN, 16'd0, 32'd0, 16'd0);
    for (int k = 0; k < 10; k++) send(ACT_READ, $urandom_range(0, 9), $urandom, $urandom);
    phase(7, 6, 2, rand_coef(), rand_coef(), 40);

    drain();
    $display("Sent %0d transactions including %0d runs, over grids from empty to 256x256,",
             sent, runs);
    $display("with loads, reads, out-of-grid indexes and coefficient extremes.");
    if (fails == 0) begin
      $display("acoustic_wave_2d_stencil_core test passed");
    end else begin
      $display("acoustic_wave_2d_stencil_core test failed");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/awsc_pkg.sv
rtl/core/awsc_cell.sv
rtl/core/awsc_update.sv
rtl/core/acoustic_wave_2d_stencil_core.sv
test/acoustic_wave_2d_stencil_core_checker.sv
test/acoustic_wave_2d_stencil_core_tb.sv
